// ===== sv/bmsq_pkg.sv =====
// Shared types and constants for the band mean sample quantizer.
`timescale 1ns / 1ps

package bmsq_pkg;

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int BAND_W   = 8;
    localparam int COUNT_W  = 17;
    localparam int SUM_W    = 24;
    localparam int NB_W     = 9;
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // Store geometry and limits
    localparam int MAX_BANDS      = 256;
    localparam int LIMIT_W        = 25;
    localparam logic [LIMIT_W-1:0] MAX_SAMPLES = 25'd65536;
    localparam logic [NB_W-1:0]    NB_MAX      = 9'(MAX_BANDS);

    // Divider
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Store entry: count in the high bits, sum in the low bits
    localparam int ENTRY_W = COUNT_W + SUM_W;

    // Register word indexes
    localparam logic [ADDR_W-3:0] REG_NUM_BANDS = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ACCUM = 2'd1,
        OP_MAP   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

endpackage

// ===== sv/band_mean_sample_quantizer_top.sv =====
// Band mean sample quantizer: band store, bit-serial mean divider, APB register.
`timescale 1ns / 1ps

// Maps 8-bit samples to one of num_bands equal bands, band = (sample * num_bands) >> 8,
// and keeps a count and a sum per band in a 256-entry store. Accumulate adds the
// sample to its band (dropped with status 1 once MAX_SAMPLES have been taken), map
// returns the band's truncated mean, read returns a band's count, clear empties the
// store at once (per-entry valid bits). One item is in flight at a time. Clear,
// accumulate, read and a map of an empty band pass through the lookup, execute and
// done states; any other map also runs the restoring divider between execute and
// done, which retires one quotient bit per cycle over 24 bits. A new item is taken
// while the previous result still waits on the output register; a second finished
// result waits until the receiver takes the first.
// num_bands is written at byte address 0; 0 acts as 1, values above 256 act as 256.
module band_mean_sample_quantizer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [bmsq_pkg::OP_W-1:0]         operation,
    input  logic [bmsq_pkg::SAMPLE_W-1:0]     sample,
    input  logic [bmsq_pkg::BAND_W-1:0]       band_index,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [bmsq_pkg::COUNT_W-1:0]      value,
    output logic [bmsq_pkg::BAND_W-1:0]       band,
    output logic [bmsq_pkg::COUNT_W-1:0]      total_samples,
    output logic                              status,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bmsq_pkg::ADDR_W-1:0]       paddr,
    input  logic [bmsq_pkg::DATA_W-1:0]       pwdata,
    output logic [bmsq_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_EXEC   = 5'b00100,
        S_DIV    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    // Control registers
    state_t                              state_reg, state_next;
    logic [bmsq_pkg::MAX_BANDS-1:0]      valid_reg, valid_next;
    logic [bmsq_pkg::COUNT_W-1:0]        total_reg, total_next;
    logic [bmsq_pkg::NB_W-1:0]           num_bands_reg, num_bands_next;
    logic                                out_valid_reg, out_valid_next;
    logic [bmsq_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;

    // Payload registers
    bmsq_pkg::op_t                       op_reg, op_next;
    logic [bmsq_pkg::SAMPLE_W-1:0]       sample_reg, sample_next;
    logic [bmsq_pkg::BAND_W-1:0]         band_reg, band_next;
    logic [bmsq_pkg::ENTRY_W-1:0]        rd_data_reg;
    logic [bmsq_pkg::COUNT_W-1:0]        res_value_reg, res_value_next;
    logic                                res_status_reg, res_status_next;
    logic [bmsq_pkg::SUM_W-1:0]          dvd_reg, dvd_next;
    logic [bmsq_pkg::COUNT_W-1:0]        rem_reg, rem_next;
    logic [bmsq_pkg::COUNT_W-1:0]        dsr_reg, dsr_next;
    logic [bmsq_pkg::COUNT_W-1:0]        value_reg, value_next;
    logic [bmsq_pkg::BAND_W-1:0]         band_out_reg, band_out_next;
    logic [bmsq_pkg::COUNT_W-1:0]        total_out_reg, total_out_next;
    logic                                status_out_reg, status_out_next;

    // Band store
    logic [bmsq_pkg::ENTRY_W-1:0]        store_mem [bmsq_pkg::MAX_BANDS];
    logic                                store_we;
    logic [bmsq_pkg::ENTRY_W-1:0]        store_wdata;

    // Datapath helpers
    logic                                in_accept;
    logic                                out_free;
    logic                                cfg_write;
    logic [bmsq_pkg::NB_W-1:0]           nb_eff;
    logic [bmsq_pkg::COUNT_W-1:0]        band_prod;
    logic [bmsq_pkg::COUNT_W-1:0]        entry_count;
    logic [bmsq_pkg::SUM_W-1:0]          entry_sum;
    logic                                store_full;
    logic [bmsq_pkg::COUNT_W:0]          trial;

    assign pready       = 1'b1;
    assign item_stall   = (state_reg != S_IDLE);
    assign in_accept    = item_valid && !item_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign cfg_write    = psel && penable && pwrite && pready
                          && (paddr[bmsq_pkg::ADDR_W-1:2] == bmsq_pkg::REG_NUM_BANDS);

    // Register read-back
    always_comb
    begin
        if (paddr[bmsq_pkg::ADDR_W-1:2] == bmsq_pkg::REG_NUM_BANDS)
        begin
            prdata = {{(bmsq_pkg::DATA_W-bmsq_pkg::NB_W){1'b0}}, num_bands_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Effective band count and band of the incoming sample
    always_comb
    begin
        if (num_bands_reg == '0)
        begin
            nb_eff = bmsq_pkg::NB_W'(1);
        end
        else if (num_bands_reg > bmsq_pkg::NB_MAX)
        begin
            nb_eff = bmsq_pkg::NB_MAX;
        end
        else
        begin
            nb_eff = num_bands_reg;
        end
        band_prod = {{(bmsq_pkg::COUNT_W-bmsq_pkg::SAMPLE_W){1'b0}}, sample}
                    * {{(bmsq_pkg::COUNT_W-bmsq_pkg::NB_W){1'b0}}, nb_eff};
    end

    // Looked-up entry; an entry not written since clear reads as zero
    assign entry_count = valid_reg[band_reg]
                         ? rd_data_reg[bmsq_pkg::ENTRY_W-1:bmsq_pkg::SUM_W] : '0;
    assign entry_sum   = valid_reg[band_reg] ? rd_data_reg[bmsq_pkg::SUM_W-1:0] : '0;
    assign store_full  = ({{(bmsq_pkg::LIMIT_W-bmsq_pkg::COUNT_W){1'b0}}, total_reg}
                          >= bmsq_pkg::MAX_SAMPLES);
    assign store_wdata = {entry_count + bmsq_pkg::COUNT_W'(1),
                          entry_sum + {{(bmsq_pkg::SUM_W-bmsq_pkg::SAMPLE_W){1'b0}},
                                       sample_reg}};

    // Restoring divider trial subtract
    assign trial = {rem_reg, dvd_reg[bmsq_pkg::SUM_W-1]} - {1'b0, dsr_reg};

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        total_next      = total_reg;
        num_bands_next  = num_bands_reg;
        out_valid_next  = out_valid_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        sample_next     = sample_reg;
        band_next       = band_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        value_next      = value_reg;
        band_out_next   = band_out_reg;
        total_out_next  = total_out_reg;
        status_out_next = status_out_reg;
        store_we        = 1'b0;

        if (cfg_write)
        begin
            num_bands_next = pwdata[bmsq_pkg::NB_W-1:0];
        end

        // output register drains
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = bmsq_pkg::op_t'(operation);
                    sample_next = sample;
                    unique case (bmsq_pkg::op_t'(operation))
                        bmsq_pkg::OP_CLEAR: band_next = '0;
                        bmsq_pkg::OP_READ:  band_next = band_index;
                        default:            band_next = band_prod[15:8];
                    endcase
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_value_next  = '0;
                res_status_next = 1'b0;
                state_next      = S_DONE;
                unique case (op_reg)
                    bmsq_pkg::OP_CLEAR:
                    begin
                        valid_next = '0;
                        total_next = '0;
                    end
                    bmsq_pkg::OP_ACCUM:
                    begin
                        if (store_full)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            store_we             = 1'b1;
                            valid_next[band_reg] = 1'b1;
                            total_next           = total_reg + bmsq_pkg::COUNT_W'(1);
                        end
                    end
                    bmsq_pkg::OP_MAP:
                    begin
                        if (entry_count != '0)
                        begin
                            dvd_next   = entry_sum;
                            rem_next   = '0;
                            dsr_next   = entry_count;
                            cnt_next   = bmsq_pkg::DIV_CNT_W'(bmsq_pkg::DIV_STEPS);
                            state_next = S_DIV;
                        end
                    end
                    bmsq_pkg::OP_READ:
                    begin
                        res_value_next = entry_count;
                    end
                    default:
                    begin
                        res_value_next = '0;
                    end
                endcase
            end
            S_DIV:
            begin
                // one quotient bit per cycle, quotient shifts into the dividend
                if (!trial[bmsq_pkg::COUNT_W])
                begin
                    rem_next = trial[bmsq_pkg::COUNT_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[bmsq_pkg::COUNT_W-2:0],
                                dvd_reg[bmsq_pkg::SUM_W-1]};
                end
                dvd_next = {dvd_reg[bmsq_pkg::SUM_W-2:0], !trial[bmsq_pkg::COUNT_W]};
                cnt_next = cnt_reg - bmsq_pkg::DIV_CNT_W'(1);
                if (cnt_reg == bmsq_pkg::DIV_CNT_W'(1))
                begin
                    res_value_next = dvd_next[bmsq_pkg::COUNT_W-1:0];
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    value_next      = res_value_reg;
                    band_out_next   = band_reg;
                    total_out_next  = total_reg;
                    status_out_next = res_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            total_reg     <= '0;
            num_bands_reg <= bmsq_pkg::NB_W'(1);
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            total_reg     <= total_next;
            num_bands_reg <= num_bands_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sample_reg     <= sample_next;
        band_reg       <= band_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        dsr_reg        <= dsr_next;
        value_reg      <= value_next;
        band_out_reg   <= band_out_next;
        total_out_reg  <= total_out_next;
        status_out_reg <= status_out_next;
    end

    // Band store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[band_reg] <= store_wdata;
        end
        rd_data_reg <= store_mem[band_reg];
    end

    assign result_valid  = out_valid_reg;
    assign value         = value_reg;
    assign band          = band_out_reg;
    assign total_samples = total_out_reg;
    assign status        = status_out_reg;

endmodule

// ===== test/band_mean_sample_quantizer_top_tb.sv =====
// Testbench for the band mean sample quantizer: directed table, then random passes.
`timescale 1ns / 1ps

module band_mean_sample_quantizer_top_tb;

    // One result beat as seen on the result channel
    typedef struct packed {
        logic [bmsq_pkg::COUNT_W-1:0] value;
        logic [bmsq_pkg::BAND_W-1:0]  band;
        logic [bmsq_pkg::COUNT_W-1:0] total;
        logic                         status;
    } quant_result_t;

    // Directed stimulus row; typed rows carry their own expected beat
    typedef struct packed {
        bmsq_pkg::op_t                 op;
        logic [bmsq_pkg::SAMPLE_W-1:0] smp;
        logic [bmsq_pkg::BAND_W-1:0]   idx;
        logic                          typed;
        quant_result_t                 res;
    } dir_row_t;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 52;
    localparam int N_ROWS = 15;
    localparam int N_PHASES = 8;

    // Reset value of num_bands is 1, so every sample lands in band 0 here
    localparam dir_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{bmsq_pkg::OP_READ,  8'h00, 8'h00, 1'b1, '{17'd0,   8'd0,   17'd0, 1'b0}},
        '{bmsq_pkg::OP_READ,  8'h00, 8'hFF, 1'b1, '{17'd0,   8'd255, 17'd0, 1'b0}},
        '{bmsq_pkg::OP_MAP,   8'hFF, 8'h00, 1'b1, '{17'd0,   8'd0,   17'd0, 1'b0}},
        '{bmsq_pkg::OP_ACCUM, 8'h00, 8'hFF, 1'b1, '{17'd0,   8'd0,   17'd1, 1'b0}},
        '{bmsq_pkg::OP_ACCUM, 8'hFF, 8'h00, 1'b1, '{17'd0,   8'd0,   17'd2, 1'b0}},
        '{bmsq_pkg::OP_MAP,   8'h80, 8'h00, 1'b1, '{17'd127, 8'd0,   17'd2, 1'b0}},
        '{bmsq_pkg::OP_READ,  8'hFF, 8'h00, 1'b1, '{17'd2,   8'd0,   17'd2, 1'b0}},
        '{bmsq_pkg::OP_CLEAR, 8'hAA, 8'h55, 1'b1, '{17'd0,   8'd0,   17'd0, 1'b0}},
        '{bmsq_pkg::OP_ACCUM, 8'hFF, 8'h00, 1'b1, '{17'd0,   8'd0,   17'd1, 1'b0}},
        '{bmsq_pkg::OP_MAP,   8'h00, 8'h00, 1'b1, '{17'd255, 8'd0,   17'd1, 1'b0}},
        '{bmsq_pkg::OP_ACCUM, 8'h01, 8'h00, 1'b0, '0},
        '{bmsq_pkg::OP_ACCUM, 8'hFE, 8'h00, 1'b0, '0},
        '{bmsq_pkg::OP_MAP,   8'h4D, 8'h00, 1'b0, '0},
        '{bmsq_pkg::OP_READ,  8'h00, 8'h00, 1'b0, '0},
        '{bmsq_pkg::OP_CLEAR, 8'h55, 8'hAA, 1'b1, '{17'd0,   8'd0,   17'd0, 1'b0}}
    };

    // Band split per phase: extremes, out-of-range values and a few in between
    localparam int NB_PLAN [N_PHASES] = '{256, 511, 3, 0, 300, 1, 100, 17};
    // Idling per phase, in percent: none, sender, receiver, both
    localparam int SEND_IDLE [4] = '{0, 56, 0, 16};
    localparam int RECV_STALL [4] = '{0, 0, 56, 16};

    logic                          clk;
    logic                          rst_n;
    logic                          item_valid;
    logic                          item_stall;
    logic [bmsq_pkg::OP_W-1:0]     operation;
    logic [bmsq_pkg::SAMPLE_W-1:0] sample;
    logic [bmsq_pkg::BAND_W-1:0]   band_index;
    logic                          result_valid;
    logic                          result_stall;
    logic [bmsq_pkg::COUNT_W-1:0]  value;
    logic [bmsq_pkg::BAND_W-1:0]   band;
    logic [bmsq_pkg::COUNT_W-1:0]  total_samples;
    logic                          status;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bmsq_pkg::ADDR_W-1:0]   paddr;
    logic [bmsq_pkg::DATA_W-1:0]   pwdata;
    logic [bmsq_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // Predictor state: mirror of the band store and the register
    logic [bmsq_pkg::COUNT_W-1:0]  band_count [bmsq_pkg::MAX_BANDS];
    logic [bmsq_pkg::SUM_W-1:0]    band_sum [bmsq_pkg::MAX_BANDS];
    logic [bmsq_pkg::COUNT_W-1:0]  sample_count;
    logic [bmsq_pkg::NB_W-1:0]     cfg_num_bands;

    quant_result_t       pending_results [$];
    logic                row_typed;
    quant_result_t       row_result;
    int                  mismatches;
    int                  quiet_cycles;
    int                  items_sent;
    int                  idle_pct;
    int                  stall_pct;

    band_mean_sample_quantizer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .operation     (operation),
        .sample        (sample),
        .band_index    (band_index),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .value         (value),
        .band          (band),
        .total_samples (total_samples),
        .status        (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Band of a sample under the current register: 0 acts as 1, above 256 as 256
    function automatic logic [bmsq_pkg::BAND_W-1:0] band_of_sample(
        logic [bmsq_pkg::SAMPLE_W-1:0] s);
        logic [16:0] nb;
        logic [16:0] prod;
        nb = 17'(cfg_num_bands);
        if (nb == 17'd0)
            nb = 17'd1;
        if (nb > 17'(bmsq_pkg::MAX_BANDS))
            nb = 17'(bmsq_pkg::MAX_BANDS);
        prod = 17'(s) * nb;
        return prod[15:8];
    endfunction

    // Applies one item to the mirrored store and returns the beat it should produce
    function automatic quant_result_t band_mean_step(bmsq_pkg::op_t op,
                                                     logic [bmsq_pkg::SAMPLE_W-1:0] s,
                                                     logic [bmsq_pkg::BAND_W-1:0] idx);
        quant_result_t r;
        logic [bmsq_pkg::SUM_W-1:0] quot;
        r = '0;
        case (op)
            bmsq_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < bmsq_pkg::MAX_BANDS; i++)
                begin
                    band_count[i] = '0;
                    band_sum[i] = '0;
                end
                sample_count = '0;
            end
            bmsq_pkg::OP_ACCUM:
            begin
                r.band = band_of_sample(s);
                // store full: the sample is dropped and the beat flagged
                if ({8'b0, sample_count} >= bmsq_pkg::MAX_SAMPLES)
                    r.status = 1'b1;
                else
                begin
                    band_count[r.band] = band_count[r.band] + 1'b1;
                    band_sum[r.band] = band_sum[r.band] + bmsq_pkg::SUM_W'(s);
                    sample_count = sample_count + 1'b1;
                end
            end
            bmsq_pkg::OP_MAP:
            begin
                r.band = band_of_sample(s);
                // empty band maps to 0
                if (band_count[r.band] != '0)
                begin
                    quot = band_sum[r.band] / {7'b0, band_count[r.band]};
                    r.value = quot[bmsq_pkg::COUNT_W-1:0];
                end
            end
            default:
            begin
                r.band = idx;
                r.value = band_count[idx];
            end
        endcase
        r.total = sample_count;
        return r;
    endfunction

    task automatic note_mismatch(string why, quant_result_t e, quant_result_t g);
        mismatches++;
        if (mismatches <= 10)
            $display({"[tb] %0t %s: exp value=%0d band=%0d total=%0d status=%0b",
                      " / got value=%0d band=%0d total=%0d status=%0b"},
                     $time, why, e.value, e.band, e.total, e.status,
                     g.value, g.band, g.total, g.status);
    endtask

    // Receiver stall, redrawn every cycle
    always @(negedge clk)
    begin
        if (rst_n)
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    // Beat monitor: predicts on accepted items, checks accepted results
    always @(posedge clk)
    begin : beat_monitor
        quant_result_t exp_r;
        quant_result_t got_r;
        logic          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_valid && !result_stall)
            begin
                moved = 1'b1;
                got_r = {value, band, total_samples, status};
                if (pending_results.size() == 0)
                    note_mismatch("unexpected result", '0, got_r);
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (got_r !== exp_r)
                        note_mismatch("result mismatch", exp_r, got_r);
                end
            end
            if (item_valid && !item_stall)
            begin
                moved = 1'b1;
                exp_r = band_mean_step(bmsq_pkg::op_t'(operation), sample, band_index);
                if (row_typed)
                    exp_r = row_result;
                pending_results.push_back(exp_r);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog on cycles with no beat on either channel
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge clk);
        $display("band_mean_sample_quantizer_top_tb: FAIL");
        $finish;
    end

    // Presents one item after a random sender gap and holds it until taken
    task automatic send_item(bmsq_pkg::op_t op, logic [bmsq_pkg::SAMPLE_W-1:0] s,
                             logic [bmsq_pkg::BAND_W-1:0] idx,
                             logic typed, quant_result_t res);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        operation = op;
        sample = s;
        band_index = idx;
        row_typed = typed;
        row_result = res;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Register write over APB, only with nothing in flight
    task automatic configure(logic [bmsq_pkg::NB_W-1:0] nb);
        wait_drained();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {bmsq_pkg::REG_NUM_BANDS, 2'b00};
        pwdata = bmsq_pkg::DATA_W'(nb);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cfg_num_bands = nb;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // One quantizing pass: usually a clear, then accumulate a set, map it back, with reads and noise
    task automatic run_pass();
        logic [bmsq_pkg::SAMPLE_W-1:0] drawn [$];
        logic [bmsq_pkg::SAMPLE_W-1:0] s;
        int n;
        n = $urandom_range(12, 1);
        if ($urandom_range(5) != 0)
            send_item(bmsq_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 1'b0, '0);
        repeat (n)
        begin
            if ($urandom_range(7) == 0)
                s = $urandom_range(1) ? 8'hFF : 8'h00;
            else
                s = 8'($urandom);
            drawn.push_back(s);
            send_item(bmsq_pkg::OP_ACCUM, s, 8'($urandom), 1'b0, '0);
            // noise: any operation with any fields
            if ($urandom_range(9) == 0)
                send_item(bmsq_pkg::op_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
                          1'b0, '0);
        end
        repeat (n)
        begin
            s = drawn[$urandom_range(drawn.size() - 1)];
            send_item(bmsq_pkg::OP_MAP, s, 8'($urandom), 1'b0, '0);
            if ($urandom_range(3) == 0)
                send_item(bmsq_pkg::OP_READ, 8'($urandom),
                          $urandom_range(1) ? band_of_sample(s) : 8'($urandom), 1'b0, '0);
        end
    endtask

    initial
    begin
        int phase_start;
        rst_n = 1'b0;
        item_valid = 1'b0;
        operation = bmsq_pkg::OP_CLEAR;
        sample = '0;
        band_index = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        row_typed = 1'b0;
        row_result = '0;
        mismatches = 0;
        quiet_cycles = 0;
        items_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        cfg_num_bands = 9'd1;
        sample_count = '0;
        for (int i = 0; i < bmsq_pkg::MAX_BANDS; i++)
        begin
            band_count[i] = '0;
            band_sum[i] = '0;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed table at the reset band split
        for (int i = 0; i < N_ROWS; i++)
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].idx,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

        // Random passes, one band split and one idling pattern per phase
        for (int p = 0; p < N_PHASES; p++)
        begin
            configure(bmsq_pkg::NB_W'(NB_PLAN[p]));
            idle_pct = SEND_IDLE[p % 4];
            stall_pct = RECV_STALL[p % 4];
            phase_start = items_sent;
            // maps over the store left from the last split
            repeat (3)
                send_item(bmsq_pkg::OP_MAP, 8'($urandom), 8'($urandom), 1'b0, '0);
            run_pass();
            // sender holds off until every result is back
            wait_drained();
            while (items_sent - phase_start < PHASE_ITEMS)
                run_pass();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("band_mean_sample_quantizer_top_tb: PASS");
        else
            $display("band_mean_sample_quantizer_top_tb: FAIL");
        $finish;
    end

endmodule
